/* sv/lpi_pkg.sv */
`default_nettype none

package lpi_pkg;

	// default sizes
	localparam int unsigned COORD_BITS_DEF = 16;
	localparam int unsigned FRAC_BITS_DEF  = 16;

	// fixed field widths
	localparam int unsigned LINE_BITS    = 32;
	localparam int unsigned COUNT_BITS   = 16;
	localparam int unsigned CFG_IDX_BITS = 2;

	// line parameter saturation limits (magnitudes)
	localparam logic [LINE_BITS-1:0] LINE_POS_LIM = {1'b0, {(LINE_BITS-1){1'b1}}};
	localparam logic [LINE_BITS-1:0] LINE_NEG_LIM = {1'b1, {(LINE_BITS-1){1'b0}}};

	// configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_START_X,
		REG_START_Y,
		REG_END_X,
		REG_END_Y
	} cfg_reg_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL,
		ST_SIGN,
		ST_START_S,
		ST_DIV_S,
		ST_START_T,
		ST_DIV_T,
		ST_FIN
	} state_t;

	// multiplier schedule: one product per step, last step only drains
	typedef enum logic [2:0] {
		MS_DEN_P,
		MS_DEN_N,
		MS_SN_P,
		MS_SN_N,
		MS_TN_P,
		MS_TN_N,
		MS_DRAIN
	} mul_step_t;

	// controller to datapath
	typedef struct packed {
		logic      accept;
		logic      diff;
		logic      mul_en;
		mul_step_t mul_step;
		logic      sign;
		logic      div_start;
		logic      div_mode_t;
		logic      fin;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic have_prev;
		logic hit;
		logic div_busy;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

/* sv/lpi_div.sv */
`default_nettype none

module lpi_div #(
	parameter int unsigned MAG_BITS  = 35,
	parameter int unsigned FRAC_BITS = lpi_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          mode_t,
	input  wire logic [MAG_BITS-1:0]           num,
	input  wire logic [MAG_BITS-1:0]           den,
	output logic                               busy,
	output logic [lpi_pkg::LINE_BITS-1:0]      quo,
	output logic                               ovf
);

	localparam int unsigned LB   = lpi_pkg::LINE_BITS;
	localparam int unsigned NW   = MAG_BITS + LB;
	localparam int unsigned CNTW = $clog2(LB + 1);

	logic [NW-1:0]       nfull;
	logic [MAG_BITS-1:0] rem_init;
	logic [LB-1:0]       sh_init;
	logic [CNTW-1:0]     steps;
	logic [MAG_BITS:0]   trial;
	logic [MAG_BITS:0]   diff;
	logic                ge;

	logic [MAG_BITS-1:0] rem_q;
	logic [LB-1:0]       sh_q;
	logic [LB-1:0]       quo_q;
	logic                ovf_q;
	logic [CNTW-1:0]     cnt_q;

	// dividend is num * 2^frac; high part seeds the remainder, the rest shifts in
	always_comb begin
		nfull    = NW'(num) << FRAC_BITS;
		rem_init = mode_t ? MAG_BITS'(nfull >> LB) : MAG_BITS'(nfull >> (FRAC_BITS + 1));
		sh_init  = mode_t ? nfull[LB-1:0]
			: (LB'(nfull[FRAC_BITS:0]) << (LB - FRAC_BITS - 1));
		steps    = mode_t ? CNTW'(LB) : CNTW'(FRAC_BITS + 1);
	end

	// one restoring step
	always_comb begin
		trial = {rem_q, sh_q[LB-1]};
		diff  = trial - {1'b0, den};
		ge    = trial >= {1'b0, den};
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= steps;
		end else if (busy) begin
			cnt_q <= cnt_q - CNTW'(1);
		end
	end

	// remainder, dividend bits and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			sh_q  <= sh_init;
			quo_q <= '0;
			ovf_q <= mode_t && (rem_init >= den);
		end else if (busy) begin
			rem_q <= ge ? diff[MAG_BITS-1:0] : trial[MAG_BITS-1:0];
			sh_q  <= sh_q << 1;
			quo_q <= {quo_q[LB-2:0], ge};
		end
	end

	assign busy = cnt_q != '0;
	assign quo  = quo_q;
	assign ovf  = ovf_q;

endmodule

`default_nettype wire

/* sv/lpi_ctrl.sv */
`default_nettype none

module lpi_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire lpi_pkg::dp_sts_t sts,
	output lpi_pkg::dp_cmd_t      cmd
);

	lpi_pkg::state_t    state_q;
	lpi_pkg::state_t    state_d;
	lpi_pkg::mul_step_t mul_step_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// multiplier step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_step_q <= lpi_pkg::MS_DEN_P;
		end else if (state_q == lpi_pkg::ST_DIFF) begin
			mul_step_q <= lpi_pkg::MS_DEN_P;
		end else if (state_q == lpi_pkg::ST_MUL && mul_step_q != lpi_pkg::MS_DRAIN) begin
			mul_step_q <= lpi_pkg::mul_step_t'(mul_step_q + 3'd1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lpi_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.have_prev ? lpi_pkg::ST_DIFF : lpi_pkg::ST_FIN;
				end
			end
			lpi_pkg::ST_DIFF: state_d = lpi_pkg::ST_MUL;
			lpi_pkg::ST_MUL: begin
				if (mul_step_q == lpi_pkg::MS_DRAIN) begin
					state_d = lpi_pkg::ST_SIGN;
				end
			end
			lpi_pkg::ST_SIGN: state_d = lpi_pkg::ST_START_S;
			lpi_pkg::ST_START_S: begin
				state_d = sts.hit ? lpi_pkg::ST_DIV_S : lpi_pkg::ST_FIN;
			end
			lpi_pkg::ST_DIV_S: begin
				if (!sts.div_busy) begin
					state_d = lpi_pkg::ST_START_T;
				end
			end
			lpi_pkg::ST_START_T: state_d = lpi_pkg::ST_DIV_T;
			lpi_pkg::ST_DIV_T: begin
				if (!sts.div_busy) begin
					state_d = lpi_pkg::ST_FIN;
				end
			end
			lpi_pkg::ST_FIN: begin
				if (sts.out_free) begin
					state_d = lpi_pkg::ST_IDLE;
				end
			end
			default: state_d = lpi_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd          = '0;
		cmd.mul_step = mul_step_q;
		in_stall     = 1'b1;
		case (state_q)
			lpi_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			lpi_pkg::ST_DIFF:    cmd.diff = 1'b1;
			lpi_pkg::ST_MUL:     cmd.mul_en = 1'b1;
			lpi_pkg::ST_SIGN:    cmd.sign = 1'b1;
			lpi_pkg::ST_START_S: cmd.div_start = sts.hit;
			lpi_pkg::ST_START_T: begin
				cmd.div_start  = 1'b1;
				cmd.div_mode_t = 1'b1;
			end
			lpi_pkg::ST_FIN:     cmd.fin = sts.out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

/* sv/lpi_dp.sv */
`default_nettype none

module lpi_dp #(
	parameter int unsigned COORD_BITS = lpi_pkg::COORD_BITS_DEF,
	parameter int unsigned FRAC_BITS  = lpi_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire lpi_pkg::dp_cmd_t                       cmd,
	output lpi_pkg::dp_sts_t                            sts,
	input  wire logic                                   cfg_we,
	input  wire logic [lpi_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  wire logic [COORD_BITS-1:0]                  cfg_wdata,
	input  wire logic signed [COORD_BITS-1:0]           vertex_x,
	input  wire logic signed [COORD_BITS-1:0]           vertex_y,
	input  wire logic                                   last_vertex,
	input  wire logic                                   out_stall,
	output logic                                        out_valid,
	output logic                                        hit,
	output logic [lpi_pkg::COUNT_BITS-1:0]              segment_index,
	output logic [FRAC_BITS:0]                          seg_param,
	output logic signed [lpi_pkg::LINE_BITS-1:0]        line_param,
	output logic                                        polyline_end
);

	localparam int unsigned DW = COORD_BITS + 1;
	localparam int unsigned PW = 2 * DW;
	localparam int unsigned CW = PW + 1;
	localparam int unsigned LB = lpi_pkg::LINE_BITS;
	localparam int unsigned NB = lpi_pkg::COUNT_BITS;

	// configuration
	logic signed [COORD_BITS-1:0] start_x_q, start_y_q, end_x_q, end_y_q;

	// polyline state
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic                         have_prev_q;
	logic [NB-1:0]                count_q;

	// current item
	logic signed [COORD_BITS-1:0] vx_q, vy_q;
	logic                         last_q;

	// differences and cross products
	logic signed [DW-1:0] dx_q, dy_q, ex_q, ey_q, wx_q, wy_q;
	logic signed [DW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod_q;
	logic                 prod_vld_q;
	lpi_pkg::mul_step_t   prod_step_q;
	logic signed [CW-1:0] den_q, sn_q, tn_q;

	// sign stage
	logic          dneg, sneg, in_rng, sign_ok;
	logic          hit_q, tneg_q;
	logic [CW-1:0] dm_q, sm_q, tm_q;
	logic [FRAC_BITS:0] seg_q;

	// divider
	logic          div_busy;
	logic [LB-1:0] div_quo;
	logic          div_ovf;

	// result formatting
	logic          t_sat;
	logic [LB-1:0] t_lim, t_mag, t_val;

	// output register
	logic                  out_valid_q;
	logic                  hit_o_q;
	logic [NB-1:0]         index_o_q;
	logic [FRAC_BITS:0]    seg_o_q;
	logic [LB-1:0]         line_o_q;
	logic                  end_o_q;
	logic                  out_free;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			end_x_q   <= COORD_BITS'(1);
			end_y_q   <= '0;
		end else if (cfg_we) begin
			case (lpi_pkg::cfg_reg_t'(cfg_index))
				lpi_pkg::REG_START_X: start_x_q <= cfg_wdata;
				lpi_pkg::REG_START_Y: start_y_q <= cfg_wdata;
				lpi_pkg::REG_END_X:   end_x_q   <= cfg_wdata;
				lpi_pkg::REG_END_Y:   end_y_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// capture vertex on input transfer
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			vx_q   <= vertex_x;
			vy_q   <= vertex_y;
			last_q <= last_vertex;
		end
	end

	// polyline state advances when the result is written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			have_prev_q <= 1'b0;
			count_q     <= '0;
		end else if (cmd.fin) begin
			prev_x_q    <= vx_q;
			prev_y_q    <= vy_q;
			have_prev_q <= !last_q;
			if (last_q) begin
				count_q <= '0;
			end else if (have_prev_q) begin
				count_q <= count_q + NB'(1);
			end
		end
	end

	// direction and offset vectors
	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			dx_q <= DW'(end_x_q) - DW'(start_x_q);
			dy_q <= DW'(end_y_q) - DW'(start_y_q);
			ex_q <= DW'(vx_q) - DW'(prev_x_q);
			ey_q <= DW'(vy_q) - DW'(prev_y_q);
			wx_q <= DW'(prev_x_q) - DW'(start_x_q);
			wy_q <= DW'(prev_y_q) - DW'(start_y_q);
		end
	end

	// multiplier operand select
	always_comb begin
		case (cmd.mul_step)
			lpi_pkg::MS_DEN_P: begin mul_a = dx_q; mul_b = ey_q; end
			lpi_pkg::MS_DEN_N: begin mul_a = dy_q; mul_b = ex_q; end
			lpi_pkg::MS_SN_P:  begin mul_a = wx_q; mul_b = dy_q; end
			lpi_pkg::MS_SN_N:  begin mul_a = wy_q; mul_b = dx_q; end
			lpi_pkg::MS_TN_P:  begin mul_a = wx_q; mul_b = ey_q; end
			lpi_pkg::MS_TN_N:  begin mul_a = wy_q; mul_b = ex_q; end
			default:           begin mul_a = dx_q; mul_b = ey_q; end
		endcase
	end

	// shared multiplier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_q <= 1'b0;
		end else begin
			prod_vld_q <= cmd.mul_en && (cmd.mul_step != lpi_pkg::MS_DRAIN);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en && cmd.mul_step != lpi_pkg::MS_DRAIN) begin
			prod_q      <= PW'(mul_a) * PW'(mul_b);
			prod_step_q <= cmd.mul_step;
		end
	end

	// cross product accumulation, from the registered product of the previous step
	always_ff @(posedge clk) begin
		if (prod_vld_q) begin
			case (prod_step_q)
				lpi_pkg::MS_DEN_P: den_q <= CW'(prod_q);
				lpi_pkg::MS_DEN_N: den_q <= den_q - CW'(prod_q);
				lpi_pkg::MS_SN_P:  sn_q  <= CW'(prod_q);
				lpi_pkg::MS_SN_N:  sn_q  <= sn_q - CW'(prod_q);
				lpi_pkg::MS_TN_P:  tn_q  <= CW'(prod_q);
				lpi_pkg::MS_TN_N:  tn_q  <= tn_q - CW'(prod_q);
				default: ;
			endcase
		end
	end

	// hit test: den nonzero, sn zero or of the same sign as den, and no larger in magnitude
	always_comb begin
		dneg    = den_q[CW-1];
		sneg    = sn_q[CW-1];
		sign_ok = (sn_q == '0) || (sneg == dneg);
		in_rng  = dneg ? (sn_q >= den_q) : (sn_q <= den_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.accept) begin
			hit_q <= 1'b0;
		end else if (cmd.sign) begin
			hit_q <= (den_q != '0) && sign_ok && in_rng;
		end
	end

	// magnitudes for the divider
	always_ff @(posedge clk) begin
		if (cmd.sign) begin
			dm_q   <= dneg ? $unsigned(-den_q) : $unsigned(den_q);
			sm_q   <= sneg ? $unsigned(-sn_q) : $unsigned(sn_q);
			tm_q   <= tn_q[CW-1] ? $unsigned(-tn_q) : $unsigned(tn_q);
			tneg_q <= (tn_q != '0) && (tn_q[CW-1] != dneg);
		end
	end

	lpi_div #(
		.MAG_BITS  (CW),
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.mode_t (cmd.div_mode_t),
		.num    (cmd.div_mode_t ? tm_q : sm_q),
		.den    (dm_q),
		.busy   (div_busy),
		.quo    (div_quo),
		.ovf    (div_ovf)
	);

	// segment quotient is taken as the line division starts
	always_ff @(posedge clk) begin
		if (cmd.div_start && cmd.div_mode_t) begin
			seg_q <= div_quo[FRAC_BITS:0];
		end
	end

	// line parameter saturation and sign
	always_comb begin
		t_lim = tneg_q ? lpi_pkg::LINE_NEG_LIM : lpi_pkg::LINE_POS_LIM;
		t_sat = div_ovf || (div_quo > t_lim);
		t_mag = t_sat ? t_lim : div_quo;
		t_val = tneg_q ? (~t_mag + LB'(1)) : t_mag;
	end

	// output register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			hit_o_q   <= hit_q;
			index_o_q <= have_prev_q ? count_q : '0;
			seg_o_q   <= hit_q ? seg_q : '0;
			line_o_q  <= hit_q ? t_val : '0;
			end_o_q   <= last_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_o_q;
	assign segment_index = index_o_q;
	assign seg_param     = seg_o_q;
	assign line_param    = line_o_q;
	assign polyline_end  = end_o_q;

	// status
	always_comb begin
		sts.have_prev = have_prev_q;
		sts.hit       = hit_q;
		sts.div_busy  = div_busy;
		sts.out_free  = out_free;
	end

endmodule

`default_nettype wire

/* sv/line_polyline_intersection.sv */
// Intersects a streamed polyline with a fixed line set through the configuration port.
// Configuration: cfg_we, cfg_index and cfg_wdata write one line coordinate per cycle
// (start x, start y, end x, end y); write only while no vertex is in flight.
// Input channel: in_valid/in_stall with vertex_x, vertex_y and last_vertex; a transfer
// takes place when in_valid is high and in_stall is low. One vertex is worked at a time.
// Output channel: out_valid/out_stall, one result per vertex, in order.
// From an input transfer to the result register write: the first vertex of a polyline goes
// straight to the write; a segment that misses first forms six products on one shared
// multiplier; a hit then also runs the shared restoring divider, which gives one quotient
// bit per cycle, FRAC_BITS + 1 bits for the segment and 32 for the line.
// The next vertex is taken in the cycle after its result is written.
// A held result does not block the next input transfer; only the write of the following
// result waits while out_stall holds the output register full.
// Reset: the line runs from (0,0) to (1,0), no previous vertex, segment count zero,
// output channel empty.
`default_nettype none

module line_polyline_intersection #(
	parameter int unsigned COORD_BITS = lpi_pkg::COORD_BITS_DEF,
	parameter int unsigned FRAC_BITS  = lpi_pkg::FRAC_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [lpi_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [COORD_BITS-1:0]              cfg_wdata,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [COORD_BITS-1:0]       vertex_x,
	input  wire logic signed [COORD_BITS-1:0]       vertex_y,
	input  wire logic                               last_vertex,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    hit,
	output logic [lpi_pkg::COUNT_BITS-1:0]          segment_index,
	output logic [FRAC_BITS:0]                      seg_param,
	output logic signed [lpi_pkg::LINE_BITS-1:0]    line_param,
	output logic                                    polyline_end
);

	lpi_pkg::dp_cmd_t cmd;
	lpi_pkg::dp_sts_t sts;

	lpi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpi_dp #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.vertex_x      (vertex_x),
		.vertex_y      (vertex_y),
		.last_vertex   (last_vertex),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.hit           (hit),
		.segment_index (segment_index),
		.seg_param     (seg_param),
		.line_param    (line_param),
		.polyline_end  (polyline_end)
	);

`ifndef ASSERT_OFF
	// one vertex at a time: a transfer closes the input until its result is written
	a_accept_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input open right after a transfer");

	// a divider start always leaves it busy
	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> sts.div_busy)
		else $error("divider not busy after start");

	// a written result shows on the output channel
	a_fin_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> out_valid)
		else $error("result written but not valid");
`endif

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int CW = lpi_pkg::COORD_BITS_DEF;
	localparam int FW = lpi_pkg::FRAC_BITS_DEF;
	localparam int SW = FW + 1;
	localparam int LB = lpi_pkg::LINE_BITS;
	localparam int NB = lpi_pkg::COUNT_BITS;
	localparam int VERTICES_PER_LINE = 220;
	localparam int LINE_SETTINGS = 9;
	localparam int MAX_REPORTS = 40;
	localparam int DIR_ROWS = 21;

	// one result of the block
	typedef struct packed {
		logic                   hit;
		logic [NB-1:0]          seg_no;
		logic [FW:0]            seg;
		logic [LB-1:0]          line;
		logic                   pend;
	} isect_t;

	typedef enum logic {
		DIR_VERTEX,
		DIR_LINE
	} dir_kind_t;

	// directed row: a vertex (a, b, last) or a new line (a, b) to (c, d)
	typedef struct packed {
		dir_kind_t              kind;
		logic signed [CW-1:0]   a;
		logic signed [CW-1:0]   b;
		logic signed [CW-1:0]   c;
		logic signed [CW-1:0]   d;
		logic                   last;
		logic                   typed;
		isect_t                 want;
	} dir_row_t;

	localparam isect_t NONE = '0;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [lpi_pkg::CFG_IDX_BITS-1:0] cfg_index;
	logic [CW-1:0]              cfg_wdata;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [CW-1:0]       vertex_x;
	logic signed [CW-1:0]       vertex_y;
	logic                       last_vertex;
	logic                       out_valid;
	logic                       out_stall;
	logic                       hit;
	logic [NB-1:0]              segment_index;
	logic [FW:0]                seg_param;
	logic signed [LB-1:0]       line_param;
	logic                       polyline_end;

	// predictor copy of the line registers and the polyline state
	longint ln_sx = 0;
	longint ln_sy = 0;
	longint ln_ex = 1;
	longint ln_ey = 0;
	longint pv_x = 0;
	longint pv_y = 0;
	bit pv_valid = 1'b0;
	logic [NB-1:0] seg_count = '0;

	isect_t pending_results[$];

	bit idle_on = 1'b1;
	int holdoff_req = 0;
	int err_count = 0;
	int n_vertices = 0;
	int n_results = 0;
	int n_hits = 0;
	int n_saturated = 0;
	int n_lines = 0;

	dir_row_t dir_tab [DIR_ROWS] = '{
		// default line along x: first vertex, then a crossing at the line start
		'{DIR_VERTEX, 0, 5, 0, 0, 1'b0, 1'b1, NONE},
		'{DIR_VERTEX, 0, -5, 0, 0, 1'b0, 1'b0, NONE},
		// zero-length segment, then a segment parallel to the line
		'{DIR_VERTEX, 0, -5, 0, 0, 1'b0, 1'b1, '{1'b0, 16'd1, 17'd0, 32'd0, 1'b0}},
		'{DIR_VERTEX, 10, -5, 0, 0, 1'b0, 1'b1, '{1'b0, 16'd2, 17'd0, 32'd0, 1'b0}},
		// segment ends on the line, then runs along it
		'{DIR_VERTEX, 10, 0, 0, 0, 1'b0, 1'b0, NONE},
		'{DIR_VERTEX, 20, 0, 0, 0, 1'b0, 1'b1, '{1'b0, 16'd4, 17'd0, 32'd0, 1'b0}},
		// coordinate extremes
		'{DIR_VERTEX, 32767, 32767, 0, 0, 1'b0, 1'b0, NONE},
		'{DIR_VERTEX, -32768, -32768, 0, 0, 1'b0, 1'b0, NONE},
		'{DIR_VERTEX, -32768, 32767, 0, 0, 1'b0, 1'b0, NONE},
		'{DIR_VERTEX, 32767, -32768, 0, 0, 1'b1, 1'b0, NONE},
		// new polyline that misses
		'{DIR_VERTEX, 100, 100, 0, 0, 1'b0, 1'b1, NONE},
		'{DIR_VERTEX, 100, 200, 0, 0, 1'b1, 1'b1, '{1'b0, 16'd0, 17'd0, 32'd0, 1'b1}},
		// crossing far past the line end saturates high
		'{DIR_LINE, -32768, 0, -32767, 0, 1'b0, 1'b0, NONE},
		'{DIR_VERTEX, 32767, 1, 0, 0, 1'b0, 1'b1, NONE},
		'{DIR_VERTEX, 32767, -1, 0, 0, 1'b1, 1'b1,
			'{1'b1, 16'd0, 17'd32768, 32'h7fff_ffff, 1'b1}},
		// crossing far behind the line start saturates low
		'{DIR_LINE, 32766, 0, 32767, 0, 1'b0, 1'b0, NONE},
		'{DIR_VERTEX, -32768, 1, 0, 0, 1'b0, 1'b1, NONE},
		'{DIR_VERTEX, -32768, -1, 0, 0, 1'b1, 1'b1,
			'{1'b1, 16'd0, 17'd32768, 32'h8000_0000, 1'b1}},
		// zero-length line never hits
		'{DIR_LINE, 7, 7, 7, 7, 1'b0, 1'b0, NONE},
		'{DIR_VERTEX, 0, 0, 0, 0, 1'b0, 1'b1, NONE},
		'{DIR_VERTEX, 10, 10, 0, 0, 1'b1, 1'b1, '{1'b0, 16'd0, 17'd0, 32'd0, 1'b1}}
	};

	line_polyline_intersection i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.vertex_x      (vertex_x),
		.vertex_y      (vertex_y),
		.last_vertex   (last_vertex),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hit           (hit),
		.segment_index (segment_index),
		.seg_param     (seg_param),
		.line_param    (line_param),
		.polyline_end  (polyline_end)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// segment from the previous vertex against the line, exact cross products
	function automatic isect_t intersect_vertex(input longint vx, input longint vy,
			input logic last);
		isect_t r;
		longint dx, dy, ex, ey, wx, wy, den, sn, tn, dm, sm, tm, tq, lim;
		bit tneg;
		r = '0;
		r.pend = last;
		if (pv_valid) begin
			dx = ln_ex - ln_sx;
			dy = ln_ey - ln_sy;
			ex = vx - pv_x;
			ey = vy - pv_y;
			wx = pv_x - ln_sx;
			wy = pv_y - ln_sy;
			den = dx * ey - dy * ex;
			sn = wx * dy - wy * dx;
			tn = wx * ey - wy * ex;
			dm = den < 0 ? -den : den;
			sm = sn < 0 ? -sn : sn;
			tm = tn < 0 ? -tn : tn;
			r.seg_no = seg_count;
			// hit needs a nonzero denominator and 0 <= s <= 1
			if (den != 0 && (sn == 0 || ((sn < 0) == (den < 0))) && sm <= dm) begin
				tneg = (tn != 0) && ((tn < 0) != (den < 0));
				lim = tneg ? (longint'(1) <<< 31) : (longint'(1) <<< 31) - 1;
				tq = (tm <<< FW) / dm;
				if (tq > lim)
					tq = lim;
				r.hit = 1'b1;
				r.seg = SW'((sm <<< FW) / dm);
				r.line = LB'(tneg ? -tq : tq);
			end
			seg_count = seg_count + 1'b1;
		end
		pv_x = vx;
		pv_y = vy;
		pv_valid = !last;
		if (last)
			seg_count = '0;
		return r;
	endfunction

	function automatic logic signed [CW-1:0] rand_coord();
		return CW'($urandom);
	endfunction

	function automatic logic signed [CW-1:0] tiny_coord();
		return CW'(int'($urandom_range(8)) - 4);
	endfunction

	// next vertex: anywhere, near the line, repeated, parallel, or on the line
	function automatic void pick_vertex(output logic signed [CW-1:0] x, y);
		longint px, py, f;
		int unsigned mode;
		mode = $urandom_range(99);
		px = rand_coord();
		py = rand_coord();
		if (mode < 35) begin
			// anywhere
		end else if (mode < 65) begin
			f = $urandom_range(16);
			px = ln_sx + (ln_ex - ln_sx) * f / 16 + longint'($urandom_range(128)) - 64;
			py = ln_sy + (ln_ey - ln_sy) * f / 16 + longint'($urandom_range(128)) - 64;
		end else if (mode < 75) begin
			if (pv_valid) begin
				px = pv_x;
				py = pv_y;
			end
		end else if (mode < 85) begin
			f = longint'($urandom_range(6)) - 3;
			if (pv_valid) begin
				px = pv_x + (ln_ex - ln_sx) * f;
				py = pv_y + (ln_ey - ln_sy) * f;
			end
		end else begin
			f = longint'($urandom_range(2)) - 1;
			px = ln_sx + (ln_ex - ln_sx) * f;
			py = ln_sy + (ln_ey - ln_sy) * f;
		end
		if (px < -32768 || px > 32767 || py < -32768 || py > 32767) begin
			px = rand_coord();
			py = rand_coord();
		end
		x = CW'(px);
		y = CW'(py);
	endfunction

	// one vertex transfer, called and returning at a falling edge
	task automatic send_vertex(input logic signed [CW-1:0] x, y, input logic last,
			input logic typed, input isect_t want);
		isect_t pred;
		if (idle_on && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		in_valid <= 1'b1;
		vertex_x <= x;
		vertex_y <= y;
		last_vertex <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pred = intersect_vertex(x, y, last);
		pending_results = {pending_results, (typed ? want : pred)};
		n_vertices++;
		@(negedge clk);
	endtask

	// stop offering and wait for every result
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic drive_reg(input lpi_pkg::cfg_reg_t r, input logic signed [CW-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v;
		case (r)
			lpi_pkg::REG_START_X: ln_sx = v;
			lpi_pkg::REG_START_Y: ln_sy = v;
			lpi_pkg::REG_END_X:   ln_ex = v;
			lpi_pkg::REG_END_Y:   ln_ey = v;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic write_line(input logic signed [CW-1:0] sx, sy, ex, ey);
		drive_reg(lpi_pkg::REG_START_X, sx);
		drive_reg(lpi_pkg::REG_START_Y, sy);
		drive_reg(lpi_pkg::REG_END_X, ex);
		drive_reg(lpi_pkg::REG_END_Y, ey);
		cfg_we <= 1'b0;
		n_lines++;
	endtask

	task automatic note_field(input string name, input longint want, input longint got);
		if (want != got) begin
			err_count++;
			if (err_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin : receiver
		int hold;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_req > 0) begin
				hold = holdoff_req;
				holdoff_req = 0;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				out_stall <= idle_on && ($urandom_range(99) < 11);
			end
		end
	end

	// result checker
	always @(posedge clk) begin : result_check
		isect_t want;
		isect_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{hit, segment_index, seg_param, line_param, polyline_end};
			n_results++;
			if (got.hit) begin
				n_hits++;
				if (got.line == lpi_pkg::LINE_POS_LIM || got.line == lpi_pkg::LINE_NEG_LIM)
					n_saturated++;
			end
			if (pending_results.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("%0t: result transfer with none expected, actual %0h", $time, got);
			end else begin
				want = pending_results.pop_front();
				note_field("hit", want.hit, got.hit);
				note_field("segment_index", want.seg_no, got.seg_no);
				note_field("seg_param", want.seg, got.seg);
				note_field("line_param", want.line, got.line);
				note_field("polyline_end", want.pend, got.pend);
			end
		end
	end

	// run limit
	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		int i, p, v, len, cnt;
		logic signed [CW-1:0] x, y;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = lpi_pkg::REG_START_X;
		cfg_wdata = '0;
		in_valid = 1'b0;
		vertex_x = '0;
		vertex_y = '0;
		last_vertex = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (i = 0; i < DIR_ROWS; i++) begin
			if (dir_tab[i].kind == DIR_LINE) begin
				settle();
				write_line(dir_tab[i].a, dir_tab[i].b, dir_tab[i].c, dir_tab[i].d);
			end else begin
				send_vertex(dir_tab[i].a, dir_tab[i].b, dir_tab[i].last,
					dir_tab[i].typed, dir_tab[i].want);
			end
		end

		// random polylines under a series of line settings
		for (p = 0; p < LINE_SETTINGS; p++) begin
			settle();
			case (p)
				0: write_line(0, 0, 1, 0);
				1: write_line(-32768, -32768, 32767, 32767);
				2: write_line(32767, -32768, -32768, 32767);
				4: write_line(0, -32768, 0, 32767);
				5: write_line(tiny_coord(), tiny_coord(), tiny_coord(), tiny_coord());
				6: write_line(-32768, 0, -32767, 0);
				7: write_line(123, -45, 123, -45);
				default: write_line(rand_coord(), rand_coord(), rand_coord(), rand_coord());
			endcase
			idle_on = (p != 4);
			// hold the output long enough for the input to back up
			if (p == 2)
				holdoff_req = 600;
			cnt = 0;
			while (cnt < VERTICES_PER_LINE) begin
				len = ($urandom_range(19) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
				for (v = 0; v < len; v++) begin
					pick_vertex(x, y);
					send_vertex(x, y, v == len - 1, 1'b0, NONE);
					cnt++;
				end
			end
		end
		idle_on = 1'b1;

		settle();
		repeat (100) @(posedge clk);
		$display("covered %0d vertices over %0d line settings: %0d results, %0d hits, %0d saturated",
			n_vertices, n_lines, n_results, n_hits, n_saturated);
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* files.f */
sv/lpi_pkg.sv
sv/lpi_div.sv
sv/lpi_ctrl.sv
sv/lpi_dp.sv
sv/line_polyline_intersection.sv
verif/tb_top.sv
